// ===== hw/rtl/mpool_pkg.sv =====
// Shared types, constants and register codes for the max pooling block.
// Used by every module under hw/rtl except mpool_ram; depends on nothing.
package mpool_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_KERNEL   = 8;
    localparam int DATA_BITS    = 16;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int PAD_LIMIT    = 4;
    localparam int STRIDE_LIMIT = 15;

    localparam int STORE_DEPTH  = MAX_KERNEL * MAX_WIDTH;
    localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
    localparam int WIDTH_BITS   = $clog2(MAX_WIDTH);
    localparam int KERNEL_BITS  = $clog2(MAX_KERNEL);
    localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);

    // configuration register field widths
    localparam int H_BITS   = 13;
    localparam int W_BITS   = 9;
    localparam int K_BITS   = 4;
    localparam int S_BITS   = 4;
    localparam int P_BITS   = 3;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 4;

    // result field widths
    localparam int OFF_BITS     = 6;
    localparam int OUT_ROW_BITS = 13;
    localparam int OUT_COL_BITS = 9;
    localparam int OUT_FIELD_BITS = DATA_BITS + OFF_BITS + OUT_ROW_BITS + OUT_COL_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    // signed window positions, with headroom for padding and stride steps
    localparam int ROW_SW = 15;
    localparam int COL_SW = 11;

    typedef logic signed [ROW_SW-1:0] row_pos_t;
    typedef logic signed [COL_SW-1:0] col_pos_t;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_IN_HEIGHT   = 4'd0;
    localparam cfg_index_t REG_IN_WIDTH    = 4'd1;
    localparam cfg_index_t REG_KERNEL_H    = 4'd2;
    localparam cfg_index_t REG_KERNEL_W    = 4'd3;
    localparam cfg_index_t REG_STRIDE_ROWS = 4'd4;
    localparam cfg_index_t REG_STRIDE_COLS = 4'd5;
    localparam cfg_index_t REG_PAD_ROWS    = 4'd6;
    localparam cfg_index_t REG_PAD_COLS    = 4'd7;

    // effective geometry after clamping, plus restart strobe
    typedef struct packed {
        logic              restart;
        logic [H_BITS-1:0] h;
        logic [W_BITS-1:0] w;
        logic [K_BITS-1:0] kh;
        logic [K_BITS-1:0] kw;
        logic [S_BITS-1:0] sr;
        logic [S_BITS-1:0] sc;
        logic [P_BITS-1:0] pr;
        logic [P_BITS-1:0] pc;
    } geom_t;

    // one read issued to the compare unit
    typedef struct packed {
        logic                hit;
        logic                first;
        logic [OFF_BITS-1:0] off;
    } scan_tag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } seq_state_t;

endpackage

// ===== hw/rtl/mpool_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpool_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/mpool_ctrl.sv =====
// Configuration registers and clamped pooling geometry.
// Depends on mpool_pkg.
module mpool_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  mpool_pkg::cfg_index_t               cfg_index,
    input  logic [mpool_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output mpool_pkg::geom_t                    geom
);

    logic [mpool_pkg::H_BITS-1:0] in_height_reg;
    logic [mpool_pkg::W_BITS-1:0] in_width_reg;
    logic [mpool_pkg::K_BITS-1:0] kernel_h_reg;
    logic [mpool_pkg::K_BITS-1:0] kernel_w_reg;
    logic [mpool_pkg::S_BITS-1:0] stride_r_reg;
    logic [mpool_pkg::S_BITS-1:0] stride_c_reg;
    logic [mpool_pkg::P_BITS-1:0] pad_r_reg;
    logic [mpool_pkg::P_BITS-1:0] pad_c_reg;
    logic                         known;
    logic [mpool_pkg::K_BITS-1:0] kh;
    logic [mpool_pkg::K_BITS-1:0] kw;
    logic [mpool_pkg::K_BITS-1:0] lim_r;
    logic [mpool_pkg::K_BITS-1:0] lim_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg <= mpool_pkg::H_BITS'(8);
            in_width_reg  <= mpool_pkg::W_BITS'(8);
            kernel_h_reg  <= mpool_pkg::K_BITS'(2);
            kernel_w_reg  <= mpool_pkg::K_BITS'(2);
            stride_r_reg  <= mpool_pkg::S_BITS'(2);
            stride_c_reg  <= mpool_pkg::S_BITS'(2);
            pad_r_reg     <= '0;
            pad_c_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mpool_pkg::REG_IN_HEIGHT:   in_height_reg <= cfg_data[mpool_pkg::H_BITS-1:0];
                mpool_pkg::REG_IN_WIDTH:    in_width_reg  <= cfg_data[mpool_pkg::W_BITS-1:0];
                mpool_pkg::REG_KERNEL_H:    kernel_h_reg  <= cfg_data[mpool_pkg::K_BITS-1:0];
                mpool_pkg::REG_KERNEL_W:    kernel_w_reg  <= cfg_data[mpool_pkg::K_BITS-1:0];
                mpool_pkg::REG_STRIDE_ROWS: stride_r_reg  <= cfg_data[mpool_pkg::S_BITS-1:0];
                mpool_pkg::REG_STRIDE_COLS: stride_c_reg  <= cfg_data[mpool_pkg::S_BITS-1:0];
                mpool_pkg::REG_PAD_ROWS:    pad_r_reg     <= cfg_data[mpool_pkg::P_BITS-1:0];
                mpool_pkg::REG_PAD_COLS:    pad_c_reg     <= cfg_data[mpool_pkg::P_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        known = 1'b0;
        unique case (cfg_index) inside
            mpool_pkg::REG_IN_HEIGHT, mpool_pkg::REG_IN_WIDTH, mpool_pkg::REG_KERNEL_H,
            mpool_pkg::REG_KERNEL_W, mpool_pkg::REG_STRIDE_ROWS, mpool_pkg::REG_STRIDE_COLS,
            mpool_pkg::REG_PAD_ROWS, mpool_pkg::REG_PAD_COLS: known = 1'b1;
            default: known = 1'b0;
        endcase

        // zero reads as one, oversize saturates
        kh = (kernel_h_reg == '0) ? mpool_pkg::K_BITS'(1)
           : (kernel_h_reg > mpool_pkg::K_BITS'(mpool_pkg::MAX_KERNEL))
             ? mpool_pkg::K_BITS'(mpool_pkg::MAX_KERNEL) : kernel_h_reg;
        kw = (kernel_w_reg == '0) ? mpool_pkg::K_BITS'(1)
           : (kernel_w_reg > mpool_pkg::K_BITS'(mpool_pkg::MAX_KERNEL))
             ? mpool_pkg::K_BITS'(mpool_pkg::MAX_KERNEL) : kernel_w_reg;
        lim_r = (kh - 1'b1 < mpool_pkg::K_BITS'(mpool_pkg::PAD_LIMIT))
              ? kh - 1'b1 : mpool_pkg::K_BITS'(mpool_pkg::PAD_LIMIT);
        lim_c = (kw - 1'b1 < mpool_pkg::K_BITS'(mpool_pkg::PAD_LIMIT))
              ? kw - 1'b1 : mpool_pkg::K_BITS'(mpool_pkg::PAD_LIMIT);

        geom.restart = cfg_valid && known;
        geom.h  = (in_height_reg == '0) ? mpool_pkg::H_BITS'(1)
                : (in_height_reg > mpool_pkg::H_BITS'(mpool_pkg::HEIGHT_LIMIT))
                  ? mpool_pkg::H_BITS'(mpool_pkg::HEIGHT_LIMIT) : in_height_reg;
        geom.w  = (in_width_reg == '0) ? mpool_pkg::W_BITS'(1)
                : (in_width_reg > mpool_pkg::W_BITS'(mpool_pkg::MAX_WIDTH))
                  ? mpool_pkg::W_BITS'(mpool_pkg::MAX_WIDTH) : in_width_reg;
        geom.kh = kh;
        geom.kw = kw;
        geom.sr = (stride_r_reg == '0) ? mpool_pkg::S_BITS'(1) : stride_r_reg;
        geom.sc = (stride_c_reg == '0) ? mpool_pkg::S_BITS'(1) : stride_c_reg;
        geom.pr = (mpool_pkg::K_BITS'(pad_r_reg) > lim_r)
                ? lim_r[mpool_pkg::P_BITS-1:0] : pad_r_reg;
        geom.pc = (mpool_pkg::K_BITS'(pad_c_reg) > lim_c)
                ? lim_c[mpool_pkg::P_BITS-1:0] : pad_c_reg;
    end

endmodule

// ===== hw/rtl/mpool_cmp.sv =====
// Shared compare unit: running maximum and first-wins argmax over one window.
// Depends on mpool_pkg; data arrives in the cycle after its tag.
module mpool_cmp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mpool_pkg::scan_tag_t                tag,
    input  logic [mpool_pkg::DATA_BITS-1:0]     rd_data,
    output logic [mpool_pkg::DATA_BITS-1:0]     best,
    output logic [mpool_pkg::OFF_BITS-1:0]      best_off
);

    mpool_pkg::scan_tag_t              tag_reg;
    logic                              found_reg;
    logic                              found_next;
    logic [mpool_pkg::DATA_BITS-1:0]   best_reg;
    logic [mpool_pkg::OFF_BITS-1:0]    off_reg;
    logic                              take;

    always_comb
    begin
        // strict compare keeps the earliest position on a tie
        take = tag_reg.hit &&
               (tag_reg.first || !found_reg || ($signed(rd_data) > $signed(best_reg)));
        found_next = (found_reg && !tag_reg.first) || take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            tag_reg   <= tag;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg <= rd_data;
            off_reg  <= tag_reg.off;
        end
    end

    assign best     = best_reg;
    assign best_off = off_reg;

endmodule

// ===== hw/rtl/max_pool2d_argmax_stream_unit.sv =====
// Sequence: a pixel that closes no window is only stored; each window it closes is then
// scanned with one line store read per kernel position through the shared compare unit,
// followed by a drain state and an output beat, which waits out any output stall.
// Throughput: one pixel at a time; s_axis_tready is low while windows are scanned and sent.
// Reset: rst_n clears counters and registers to the default 8x8, 2x2, stride 2 setup;
// the line store is not cleared, and a write to a known register restarts the plane.
module max_pool2d_argmax_stream_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [mpool_pkg::DATA_BITS-1:0]      s_axis_tdata,  // sample
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // pooled_value, argmax_offset, out_row, out_col, zero fill
    output logic [mpool_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    output logic                                 m_axis_tlast,  // run_last
    output logic                                 m_axis_tuser,  // plane_done
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  mpool_pkg::cfg_index_t                cfg_index,
    input  logic [mpool_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    mpool_pkg::geom_t     g;
    mpool_pkg::seq_state_t state_reg, state_next;
    mpool_pkg::scan_tag_t tag;

    logic [mpool_pkg::ROW_BITS-1:0]     row_reg;
    logic [mpool_pkg::WIDTH_BITS-1:0]   col_reg;
    mpool_pkg::row_pos_t                rst_reg;
    mpool_pkg::col_pos_t                cst_reg;
    logic [mpool_pkg::OUT_ROW_BITS-1:0] ro_reg;
    logic [mpool_pkg::OUT_COL_BITS-1:0] co_reg;

    logic [mpool_pkg::OUT_ROW_BITS-1:0] cur_oh_reg;
    mpool_pkg::row_pos_t                cur_rst_reg;
    logic [mpool_pkg::OUT_COL_BITS-1:0] cur_ow_reg;
    mpool_pkg::col_pos_t                cur_cst_reg;
    logic [mpool_pkg::OUT_COL_BITS-1:0] base_ow_reg;
    mpool_pkg::col_pos_t                base_cst_reg;
    logic                               lrow_reg;
    logic                               lcol_reg;
    logic [mpool_pkg::KERNEL_BITS-1:0]  si_reg;
    logic [mpool_pkg::KERNEL_BITS-1:0]  sj_reg;
    logic [mpool_pkg::OFF_BITS-1:0]     soff_reg;

    logic                               accept;
    logic                               emit_done;
    logic [mpool_pkg::ROW_BITS-1:0]     r_in;
    logic [mpool_pkg::WIDTH_BITS-1:0]   c_in;
    mpool_pkg::row_pos_t                rst_e;
    mpool_pkg::col_pos_t                cst_e;
    logic [mpool_pkg::OUT_ROW_BITS-1:0] ro_e;
    logic [mpool_pkg::OUT_COL_BITS-1:0] co_e;
    logic                               last_row;
    logic                               last_col;
    logic                               row_has;
    logic                               col_has;
    mpool_pkg::row_pos_t                kh_s;
    mpool_pkg::col_pos_t                kw_s;
    mpool_pkg::row_pos_t                row_lim;
    mpool_pkg::col_pos_t                col_lim;
    mpool_pkg::row_pos_t                nxt_rst;
    mpool_pkg::col_pos_t                nxt_cst;
    logic                               row_more;
    logic                               col_more;
    logic                               last_pos;
    mpool_pkg::row_pos_t                ih;
    mpool_pkg::col_pos_t                iw;
    logic [mpool_pkg::ADDR_BITS-1:0]    wr_addr;
    logic [mpool_pkg::ADDR_BITS-1:0]    rd_addr;
    logic [mpool_pkg::DATA_BITS-1:0]    rd_data;
    logic [mpool_pkg::DATA_BITS-1:0]    best;
    logic [mpool_pkg::OFF_BITS-1:0]     best_off;

    mpool_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (g)
    );

    mpool_ram #(
        .WIDTH (mpool_pkg::DATA_BITS),
        .DEPTH (mpool_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (state_reg == mpool_pkg::ST_SCAN),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mpool_cmp u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag      (tag),
        .rd_data  (rd_data),
        .best     (best),
        .best_off (best_off)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == mpool_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == mpool_pkg::ST_OUT);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign emit_done     = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        kh_s    = mpool_pkg::row_pos_t'(g.kh);
        kw_s    = mpool_pkg::col_pos_t'(g.kw);
        row_lim = mpool_pkg::row_pos_t'(g.h) + mpool_pkg::row_pos_t'(g.pr);
        col_lim = mpool_pkg::col_pos_t'(g.w) + mpool_pkg::col_pos_t'(g.pc);

        // position of this pixel; out-of-range counters restart the plane
        if ((mpool_pkg::H_BITS'(row_reg) >= g.h) || (mpool_pkg::W_BITS'(col_reg) >= g.w))
        begin
            r_in = '0;
            c_in = '0;
        end
        else
        begin
            r_in = row_reg;
            c_in = col_reg;
        end

        // first row or column starts from the padded origin
        rst_e = (r_in == '0) ? -mpool_pkg::row_pos_t'(g.pr) : rst_reg;
        ro_e  = (r_in == '0) ? '0 : ro_reg;
        cst_e = (c_in == '0) ? -mpool_pkg::col_pos_t'(g.pc) : cst_reg;
        co_e  = (c_in == '0) ? '0 : co_reg;

        last_row = (mpool_pkg::H_BITS'(r_in) == g.h - 1'b1);
        last_col = (mpool_pkg::W_BITS'(c_in) == g.w - 1'b1);
        row_has  = last_row ? (rst_e + kh_s <= row_lim)
                            : (rst_e + kh_s - mpool_pkg::row_pos_t'(1)
                               == mpool_pkg::row_pos_t'(r_in));
        col_has  = last_col ? (cst_e + kw_s <= col_lim)
                            : (cst_e + kw_s - mpool_pkg::col_pos_t'(1)
                               == mpool_pkg::col_pos_t'(c_in));

        wr_addr = {r_in[mpool_pkg::KERNEL_BITS-1:0], c_in};

        // window iteration
        nxt_rst  = cur_rst_reg + mpool_pkg::row_pos_t'(g.sr);
        nxt_cst  = cur_cst_reg + mpool_pkg::col_pos_t'(g.sc);
        row_more = lrow_reg && (nxt_rst + kh_s <= row_lim);
        col_more = lcol_reg && (nxt_cst + kw_s <= col_lim);

        // read address of the current kernel position
        ih = cur_rst_reg + mpool_pkg::row_pos_t'(si_reg);
        iw = cur_cst_reg + mpool_pkg::col_pos_t'(sj_reg);
        rd_addr = {ih[mpool_pkg::KERNEL_BITS-1:0], iw[mpool_pkg::WIDTH_BITS-1:0]};
        last_pos = (mpool_pkg::K_BITS'(si_reg) == g.kh - 1'b1) &&
                   (mpool_pkg::K_BITS'(sj_reg) == g.kw - 1'b1);

        tag.hit   = (state_reg == mpool_pkg::ST_SCAN) &&
                    (ih >= 0) && (ih < mpool_pkg::row_pos_t'(g.h)) &&
                    (iw >= 0) && (iw < mpool_pkg::col_pos_t'(g.w));
        tag.first = (state_reg == mpool_pkg::ST_SCAN) && (si_reg == '0) && (sj_reg == '0);
        tag.off   = soff_reg;
    end

    assign m_axis_tdata = {{mpool_pkg::OUT_PAD_BITS{1'b0}}, cur_ow_reg, cur_oh_reg,
                           best_off, best};
    assign m_axis_tlast = !row_more && !col_more;
    assign m_axis_tuser = !(nxt_rst + kh_s <= row_lim) && !(nxt_cst + kw_s <= col_lim);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpool_pkg::ST_IDLE:
            begin
                if (accept && row_has && col_has)
                begin
                    state_next = mpool_pkg::ST_SCAN;
                end
            end
            mpool_pkg::ST_SCAN:
            begin
                if (last_pos)
                begin
                    state_next = mpool_pkg::ST_DRAIN;
                end
            end
            mpool_pkg::ST_DRAIN:
            begin
                state_next = mpool_pkg::ST_OUT;
            end
            mpool_pkg::ST_OUT:
            begin
                if (emit_done)
                begin
                    state_next = (row_more || col_more) ? mpool_pkg::ST_SCAN
                                                        : mpool_pkg::ST_IDLE;
                end
            end
            default: state_next = mpool_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpool_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            si_reg    <= '0;
            sj_reg    <= '0;
            soff_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (g.restart)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= last_col ? '0 : c_in + 1'b1;
                row_reg <= !last_col ? r_in : (last_row ? '0 : r_in + 1'b1);
            end
            // advance the kernel scan, clear it on each new window
            if (state_reg == mpool_pkg::ST_SCAN && !last_pos)
            begin
                soff_reg <= soff_reg + 1'b1;
                if (mpool_pkg::K_BITS'(sj_reg) == g.kw - 1'b1)
                begin
                    sj_reg <= '0;
                    si_reg <= si_reg + 1'b1;
                end
                else
                begin
                    sj_reg <= sj_reg + 1'b1;
                end
            end
            else if (state_reg != mpool_pkg::ST_SCAN)
            begin
                si_reg   <= '0;
                sj_reg   <= '0;
                soff_reg <= '0;
            end
        end
    end

    // window tracking and cursors
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cst_reg <= col_has ? cst_e + mpool_pkg::col_pos_t'(g.sc) : cst_e;
            co_reg  <= col_has ? co_e + 1'b1 : co_e;
            rst_reg <= (last_col && row_has) ? rst_e + mpool_pkg::row_pos_t'(g.sr) : rst_e;
            ro_reg  <= (last_col && row_has) ? ro_e + 1'b1 : ro_e;

            cur_oh_reg   <= ro_e;
            cur_rst_reg  <= rst_e;
            cur_ow_reg   <= co_e;
            cur_cst_reg  <= cst_e;
            base_ow_reg  <= co_e;
            base_cst_reg <= cst_e;
            lrow_reg     <= last_row;
            lcol_reg     <= last_col;
        end
        else if (emit_done)
        begin
            if (col_more)
            begin
                cur_ow_reg  <= cur_ow_reg + 1'b1;
                cur_cst_reg <= nxt_cst;
            end
            else if (row_more)
            begin
                cur_oh_reg  <= cur_oh_reg + 1'b1;
                cur_rst_reg <= nxt_rst;
                cur_ow_reg  <= base_ow_reg;
                cur_cst_reg <= base_cst_reg;
            end
        end
    end

endmodule

// ===== hw/rtl/mpool_checker.sv =====
// Port-level checks for max_pool2d_argmax_stream_unit, attached by bind.
// Depends on mpool_pkg.
module mpool_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [mpool_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic                                 m_axis_tlast,
    input logic                                 m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // input is never taken while a result is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // a result never shows straight after an accepted pixel: a scan and a drain come first
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result right after input beat");

    // final window of the plane closes its run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("plane_done without run_last");

endmodule

bind max_pool2d_argmax_stream_unit mpool_checker u_mpool_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/max_pool2d_argmax_stream_checker.sv =====
`timescale 1ns / 100ps
// Watches the config, pixel and result channels of max_pool2d_argmax_stream_unit.
// Predicts pooled results and compares them field by field. Depends on mpool_pkg.
module max_pool2d_argmax_stream_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [mpool_pkg::DATA_BITS-1:0]      s_axis_tdata,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [mpool_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic                                 m_axis_tlast,
    input  logic                                 m_axis_tuser,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  mpool_pkg::cfg_index_t                cfg_index,
    input  logic [mpool_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                   errors,
    output int                                   pending
);
    import mpool_pkg::*;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] value;
        logic [OFF_BITS-1:0]         off;
        logic [OUT_ROW_BITS-1:0]     row;
        logic [OUT_COL_BITS-1:0]     col;
        logic                        last;
        logic                        done;
    } pool_result_t;

    pool_result_t pool_q[$];

    logic signed [DATA_BITS-1:0] pixels [STORE_DEPTH];
    logic [H_BITS-1:0] height_reg;
    logic [W_BITS-1:0] width_reg;
    logic [K_BITS-1:0] kh_reg, kw_reg;
    logic [S_BITS-1:0] sr_reg, sc_reg;
    logic [P_BITS-1:0] pr_reg, pc_reg;
    int row_pos, col_pos;

    assign pending = pool_q.size();

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int axis_out(int n, int k, int s, int p);
        int span;
        span = n + 2 * p - k;
        return (span < 0) ? 0 : span / s + 1;
    endfunction

    // windows along one axis whose clipped end lands on pos
    function automatic int axis_hits(int pos, int last, int k, int s, int p, int nout,
                                     output int first);
        int t;
        t = pos + p + 1 - k;
        first = (t <= 0) ? 0 : (t + s - 1) / s;
        if (pos < last)
            return (first < nout && first * s - p + k - 1 == pos) ? 1 : 0;
        return (nout > first) ? nout - first : 0;
    endfunction

    task automatic take_pixel(logic signed [DATA_BITS-1:0] px);
        int h, w, kh, kw, sr, sc, pr, pc, nh, nw, oh0, ow0, cnt_h, cnt_w;
        int ih, iw, best_off, n0;
        logic signed [DATA_BITS-1:0] best, v;
        logic found;
        pool_result_t res;
        h  = clip(height_reg, 1, HEIGHT_LIMIT);
        w  = clip(width_reg, 1, MAX_WIDTH);
        kh = clip(kh_reg, 1, MAX_KERNEL);
        kw = clip(kw_reg, 1, MAX_KERNEL);
        sr = clip(sr_reg, 1, STRIDE_LIMIT);
        sc = clip(sc_reg, 1, STRIDE_LIMIT);
        pr = clip(pr_reg, 0, (kh - 1 < PAD_LIMIT) ? kh - 1 : PAD_LIMIT);
        pc = clip(pc_reg, 0, (kw - 1 < PAD_LIMIT) ? kw - 1 : PAD_LIMIT);
        if (row_pos >= h || col_pos >= w)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        pixels[(row_pos % MAX_KERNEL) * MAX_WIDTH + col_pos] = px;
        nh = axis_out(h, kh, sr, pr);
        nw = axis_out(w, kw, sc, pc);
        cnt_h = axis_hits(row_pos, h - 1, kh, sr, pr, nh, oh0);
        cnt_w = axis_hits(col_pos, w - 1, kw, sc, pc, nw, ow0);
        n0 = pool_q.size();
        for (int a = 0; a < cnt_h; a++)
        begin
            for (int b = 0; b < cnt_w; b++)
            begin
                found = 0;
                best = '0;
                best_off = 0;
                for (int i = 0; i < kh; i++)
                begin
                    ih = (oh0 + a) * sr - pr + i;
                    if (ih < 0 || ih >= h) continue;
                    for (int j = 0; j < kw; j++)
                    begin
                        iw = (ow0 + b) * sc - pc + j;
                        if (iw < 0 || iw >= w) continue;
                        v = pixels[(ih % MAX_KERNEL) * MAX_WIDTH + iw];
                        if (!found || v > best)
                        begin
                            found = 1;
                            best = v;
                            best_off = i * kw + j;
                        end
                    end
                end
                res.value = best;
                res.off   = best_off[OFF_BITS-1:0];
                res.row   = OUT_ROW_BITS'(oh0 + a);
                res.col   = OUT_COL_BITS'(ow0 + b);
                res.last  = 0;
                res.done  = (oh0 + a == nh - 1) && (ow0 + b == nw - 1);
                pool_q.push_back(res);
            end
        end
        if (pool_q.size() > n0) pool_q[pool_q.size() - 1].last = 1;
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t want, got;
        if (!rst_n)
        begin
            height_reg = 8;
            width_reg = 8;
            kh_reg = 2;
            kw_reg = 2;
            sr_reg = 2;
            sc_reg = 2;
            pr_reg = 0;
            pc_reg = 0;
            row_pos = 0;
            col_pos = 0;
            errors = 0;
            pool_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IN_HEIGHT:   height_reg = cfg_data[H_BITS-1:0];
                    REG_IN_WIDTH:    width_reg = cfg_data[W_BITS-1:0];
                    REG_KERNEL_H:    kh_reg = cfg_data[K_BITS-1:0];
                    REG_KERNEL_W:    kw_reg = cfg_data[K_BITS-1:0];
                    REG_STRIDE_ROWS: sr_reg = cfg_data[S_BITS-1:0];
                    REG_STRIDE_COLS: sc_reg = cfg_data[S_BITS-1:0];
                    REG_PAD_ROWS:    pr_reg = cfg_data[P_BITS-1:0];
                    REG_PAD_COLS:    pc_reg = cfg_data[P_BITS-1:0];
                    default:         ;
                endcase
                if (cfg_index <= REG_PAD_COLS)
                begin
                    row_pos = 0;
                    col_pos = 0;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value = m_axis_tdata[DATA_BITS-1:0];
                got.off   = m_axis_tdata[DATA_BITS +: OFF_BITS];
                got.row   = m_axis_tdata[DATA_BITS + OFF_BITS +: OUT_ROW_BITS];
                got.col   = m_axis_tdata[DATA_BITS + OFF_BITS + OUT_ROW_BITS +: OUT_COL_BITS];
                got.last  = m_axis_tlast;
                got.done  = m_axis_tuser;
                if (pool_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: value %0d off %0d row %0d col %0d",
                                 got.value, got.off, got.row, got.col);
                end
                else
                begin
                    want = pool_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected value %0d off %0d row %0d col %0d",
                                      " last %0d done %0d, got %0d %0d %0d %0d %0d %0d"},
                                     want.value, want.off, want.row, want.col, want.last,
                                     want.done, got.value, got.off, got.row, got.col,
                                     got.last, got.done);
                    end
                end
            end
        end
    end
endmodule

// ===== sim/max_pool2d_argmax_stream_unit_test.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for max_pool2d_argmax_stream_unit: directed and random planes
// under several geometries. Depends on mpool_pkg and max_pool2d_argmax_stream_checker.
module max_pool2d_argmax_stream_unit_test;
    import mpool_pkg::*;

    logic clk, rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [DATA_BITS-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic m_axis_tlast, m_axis_tuser;
    logic cfg_valid, cfg_ready;
    cfg_index_t cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int errors, pending;
    int pixels_fed;
    int cycle_count;

    max_pool2d_argmax_stream_unit i_dut (.*);

    max_pool2d_argmax_stream_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever @(posedge clk) cycle_count++;
    end

    // quiet stretch: no idling on either side
    function automatic logic idle_now();
        if (cycle_count > 800 && cycle_count < 1600) return 0;
        return $urandom_range(0, 99) < 10;
    endfunction

    // receiver: random stalls, plus one long hold-off to back up the block
    initial
    begin
        int hold;
        logic held;
        held = 0;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && pixels_fed >= 40)
            begin
                held = 1;
                hold = 400;
                m_axis_tready <= 0;
                while (hold > 0)
                begin
                    @(posedge clk);
                    hold--;
                end
            end
            m_axis_tready <= !idle_now();
        end
    end

    function automatic logic [DATA_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(signed'($urandom_range(0, 3)) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pixel(logic [DATA_BITS-1:0] px);
        if (idle_now())
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= px;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pixels_fed++;
    endtask

    // let the block drain before touching the registers
    task automatic settle();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_BITS'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic set_geometry(int h, int w, int kh, int kw, int sr, int sc, int pr,
                                int pc);
        settle();
        write_reg(REG_IN_HEIGHT, h);
        write_reg(REG_IN_WIDTH, w);
        write_reg(REG_KERNEL_H, kh);
        write_reg(REG_KERNEL_W, kw);
        write_reg(REG_STRIDE_ROWS, sr);
        write_reg(REG_STRIDE_COLS, sc);
        write_reg(REG_PAD_ROWS, pr);
        write_reg(REG_PAD_COLS, pc);
    endtask

    task automatic feed_random(int n);
        repeat (n) send_pixel(pick_sample());
    endtask

    initial
    begin
        int random_fed, h, w, n;
        logic [DATA_BITS-1:0] directed [16];
        directed = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'h0000,
                     16'h0000, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa,
                     16'h8000, 16'h8000, 16'h8000, 16'h8000};
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        cfg_valid = 0;
        cfg_index = REG_IN_HEIGHT;
        cfg_data = '0;
        pixels_fed = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // default setup: extremes and ties in the first two rows
        foreach (directed[i]) send_pixel(directed[i]);
        feed_random(16);

        // padding clipped to kernel - 1, many windows per pixel at the edges
        set_geometry(3, 5, 3, 3, 1, 1, 7, 2);
        feed_random(15);

        // zero sizes, kernels and strides act as one; ignored write past the register list
        set_geometry(0, 0, 0, 0, 0, 0, 0, 0);
        write_reg(cfg_index_t'(9), 5);
        feed_random(3);

        // kernel larger than the padded plane: nothing comes out
        set_geometry(2, 2, 4, 4, 1, 1, 0, 0);
        feed_random(4);

        // oversized kernel and max stride, clipped padding
        set_geometry(2, 10, 15, 9, 15, 15, 7, 7);
        feed_random(20);

        // width saturates to the line store width
        set_geometry(1, 511, 1, 1, 15, 15, 0, 0);
        feed_random(20);

        random_fed = 0;
        while (random_fed < 40)
        begin
            h = $urandom_range(1, 4);
            w = $urandom_range(1, 6);
            n = h * w * $urandom_range(1, 2);
            set_geometry(h, w, $urandom_range(1, 4), $urandom_range(1, 4),
                         $urandom_range(1, 3), $urandom_range(1, 3),
                         $urandom_range(0, 3), $urandom_range(0, 3));
            feed_random(n);
            random_fed += n;
        end

        settle();
        if (errors == 0)
            $display("max_pool2d_argmax_stream_unit_test: clean");
        else
            $display("max_pool2d_argmax_stream_unit_test: errors");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("max_pool2d_argmax_stream_unit_test: errors");
        $finish;
    end
endmodule
